// ===== src/rfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfrc_pkg
// Shared constants and types for the radio frame receive checker.
// ----------------------------------------------------------------------------
package rfrc_pkg;

  localparam int MAX_FRAME = 64;

  localparam logic [7:0] TAG_PLAIN     = 8'h44;  // 'D'
  localparam logic [7:0] TAG_IDENT     = 8'h45;  // 'E'
  localparam logic [6:0] IDENT_MIN_LEN = 7'd13;
  localparam logic [6:0] MIN_LEN       = 7'd5;
  localparam logic [6:0] COUNT_SAT     = 7'd127;
  localparam logic [6:0] LEN_SAT       = 7'd64;
  localparam logic [6:0] FWD_LAST_POS  = 7'd65;
  localparam logic [6:0] FWD_FIRST_POS = 7'd5;

  localparam logic [7:0] OWN_ADDR_RST    = 8'h00;
  localparam logic [7:0] LISTEN_ADDR_RST = 8'hF0;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OWN_ADDRESS    = 2'd0;
  localparam logic [1:0] CFG_LISTEN_ADDRESS = 2'd1;
  localparam logic [1:0] CFG_LISTEN_ENABLE  = 2'd2;

  typedef struct packed {
    logic       is_verdict;
    logic [7:0] body_byte;
    logic [5:0] body_index;
    logic       frame_ok;
    logic       ack_needed;
    logic [7:0] ack_target;
    logic [7:0] ack_check;
    logic [7:0] sequence_res;
    logic       has_identity;
    logic [6:0] frame_length;
    logic       run_last;
  } result_t;

  // Results produced by one accepted byte: up to two, first one first.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== src/rfrc_in_if.sv =====
// ----------------------------------------------------------------------------
// rfrc_in_if
// Input byte channel: valid/ready handshake with one frame byte per transaction.
// ----------------------------------------------------------------------------
interface rfrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ===== src/rfrc_out_if.sv =====
// ----------------------------------------------------------------------------
// rfrc_out_if
// Result channel: valid/ready handshake with one body byte or verdict per
// transaction.
// ----------------------------------------------------------------------------
interface rfrc_out_if;
  logic       valid;
  logic       ready;
  logic       is_verdict;
  logic [7:0] body_byte;
  logic [5:0] body_index;
  logic       frame_ok;
  logic       ack_needed;
  logic [7:0] ack_target;
  logic [7:0] ack_check;
  logic [7:0] sequence_res;
  logic       has_identity;
  logic [6:0] frame_length;
  logic       run_last;

  modport source (output valid, output is_verdict, output body_byte, output body_index,
                  output frame_ok, output ack_needed, output ack_target, output ack_check,
                  output sequence_res, output has_identity, output frame_length,
                  output run_last, input ready);
  modport sink   (input valid, input is_verdict, input body_byte, input body_index,
                  input frame_ok, input ack_needed, input ack_target, input ack_check,
                  input sequence_res, input has_identity, input frame_length,
                  input run_last, output ready);
endinterface

// ===== src/rfrc_frame_core.sv =====
// ----------------------------------------------------------------------------
// rfrc_frame_core
// Frame state, configuration registers and per-byte result computation.
// ----------------------------------------------------------------------------
module rfrc_frame_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_wdata,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  input  logic            frame_end,
  output rfrc_pkg::push_t push
);
  import rfrc_pkg::*;

  logic [7:0] own_address_r;
  logic [7:0] listen_address_r;
  logic       listen_enable_r;

  logic [6:0] byte_count_r, byte_count_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;
  logic [7:0] dest_seen_r, dest_seen_nxt;
  logic [7:0] tag_seen_r, tag_seen_nxt;
  logic [7:0] source_seen_r, source_seen_nxt;
  logic [7:0] delay0_r, delay1_r;
  logic       too_long_r, too_long_nxt;

  logic       fwd;
  logic       to_own, to_listen, tag_ok, ok;
  logic [6:0] len;
  result_t    body_res, verdict_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r    <= OWN_ADDR_RST;
      listen_address_r <= LISTEN_ADDR_RST;
      listen_enable_r  <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OWN_ADDRESS:    own_address_r    <= cfg_wdata;
        CFG_LISTEN_ADDRESS: listen_address_r <= cfg_wdata;
        CFG_LISTEN_ENABLE:  listen_enable_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    too_long_nxt = too_long_r ||
                   ({1'b0, byte_count_r} >= 8'(MAX_FRAME)) ||
                   (byte_count_r >= COUNT_SAT);
    dest_seen_nxt   = (byte_count_r == 7'd0) ? rx_byte : dest_seen_r;
    tag_seen_nxt    = (byte_count_r == 7'd1) ? rx_byte : tag_seen_r;
    source_seen_nxt = (byte_count_r == 7'd2) ? rx_byte : source_seen_r;
    running_xor_nxt = (byte_count_r >= 7'd2) ? (running_xor_r ^ rx_byte) : running_xor_r;
    byte_count_nxt  = (byte_count_r < COUNT_SAT) ? (byte_count_r + 7'd1) : COUNT_SAT;

    fwd = (byte_count_r >= FWD_FIRST_POS) &&
          ({1'b0, byte_count_r} < 8'(MAX_FRAME)) &&
          (byte_count_r <= FWD_LAST_POS);

    body_res            = '0;
    body_res.body_byte  = delay1_r;
    body_res.body_index = 6'(byte_count_r - 7'd2);
    body_res.run_last   = ~frame_end;

    len       = byte_count_nxt;
    to_own    = (dest_seen_nxt == own_address_r);
    to_listen = listen_enable_r && (dest_seen_nxt == listen_address_r);
    tag_ok    = (tag_seen_nxt == TAG_PLAIN) || (tag_seen_nxt == TAG_IDENT);
    ok        = (len >= MIN_LEN) && !too_long_nxt && (to_own || to_listen) &&
                tag_ok && (running_xor_nxt == 8'd0);

    verdict_res              = '0;
    verdict_res.is_verdict   = 1'b1;
    verdict_res.frame_ok     = ok;
    verdict_res.ack_needed   = ok && to_own;
    verdict_res.ack_target   = source_seen_nxt;
    verdict_res.ack_check    = rx_byte;
    verdict_res.sequence_res = (len >= 7'd2) ? delay0_r : 8'd0;
    verdict_res.has_identity = (tag_seen_nxt == TAG_IDENT) && (len >= IDENT_MIN_LEN);
    verdict_res.frame_length = (len < LEN_SAT) ? len : LEN_SAT;
    verdict_res.run_last     = 1'b1;

    push = '0;
    if (take) begin
      push.count  = 2'({1'b0, fwd} + {1'b0, frame_end});
      push.first  = fwd ? body_res : verdict_res;
      push.second = verdict_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      running_xor_r <= '0;
      dest_seen_r   <= '0;
      tag_seen_r    <= '0;
      source_seen_r <= '0;
      delay0_r      <= '0;
      delay1_r      <= '0;
      too_long_r    <= 1'b0;
    end else if (take) begin
      if (frame_end) begin
        // The verdict closes the frame; all frame state starts over.
        byte_count_r  <= '0;
        running_xor_r <= '0;
        dest_seen_r   <= '0;
        tag_seen_r    <= '0;
        source_seen_r <= '0;
        delay0_r      <= '0;
        delay1_r      <= '0;
        too_long_r    <= 1'b0;
      end else begin
        byte_count_r  <= byte_count_nxt;
        running_xor_r <= running_xor_nxt;
        dest_seen_r   <= dest_seen_nxt;
        tag_seen_r    <= tag_seen_nxt;
        source_seen_r <= source_seen_nxt;
        delay0_r      <= rx_byte;
        delay1_r      <= delay0_r;
        too_long_r    <= too_long_nxt;
      end
    end
  end

endmodule

// ===== src/rfrc_out_queue.sv =====
// ----------------------------------------------------------------------------
// rfrc_out_queue
// Four-entry result queue that takes up to two results per cycle and hands
// out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module rfrc_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  rfrc_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output rfrc_pkg::result_t out_data
);
  import rfrc_pkg::*;

  result_t    slots_r [4];
  logic [1:0] rd_ptr_r, wr_ptr_r;
  logic [2:0] count_r;
  logic       pop;

  assign out_valid = (count_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = slots_r[rd_ptr_r];
  // Two free entries must remain after this cycle's pop to accept a byte.
  assign room      = (count_r - {2'b00, pop}) <= 3'd2;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) slots_r[wr_ptr_r] <= push.first;
    if (push.count == 2'd2) slots_r[wr_ptr_r + 2'd1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      wr_ptr_r <= wr_ptr_r + push.count;
      count_r  <= count_r + {1'b0, push.count} - {2'b00, pop};
    end
  end

endmodule

// ===== src/radio_frame_receive_checker.sv =====
// ----------------------------------------------------------------------------
// radio_frame_receive_checker
// Checks received radio frames byte by byte: address filter, tag, length and
// XOR checksum, forwarding body bytes and giving an end-of-frame verdict.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one frame byte per transaction, with frame_end on the last
//   byte of a frame. out_ch carries one result per transaction: a forwarded
//   body byte (is_verdict low) or the verdict of a frame (is_verdict high).
//   A byte can cause two results, the forwarded byte first; run_last marks the
//   final result of a byte.
//   The byte is processed in the cycle it is accepted and its results are
//   written into a four-entry result queue, whose head is offered on out_ch.
//   One byte is taken per cycle while the queue has two free entries; with the
//   receiver always ready the queue never holds more than two results, so
//   in_ch is never held off and bytes are taken back to back, one per cycle.
//   A stalled receiver fills the queue and then drops in_ch.ready.
//   The cfg port writes own_address, listen_address and listen_enable by index
//   and should be used only while no frame is in progress.
//   Synchronous reset clears all frame state and the queue and loads the
//   register defaults (own 0x00, listen 0xF0, listen enabled).
// ----------------------------------------------------------------------------
module radio_frame_receive_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  rfrc_in_if.sink    in_ch,
  rfrc_out_if.source out_ch
);
  import rfrc_pkg::*;

  push_t   push;
  result_t head;
  logic    room;
  logic    take;

  assign in_ch.ready = room;
  assign take        = in_ch.valid && room;

  rfrc_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .rx_byte   (in_ch.rx_byte),
    .frame_end (in_ch.frame_end),
    .push      (push)
  );

  rfrc_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (head)
  );

  assign out_ch.is_verdict   = head.is_verdict;
  assign out_ch.body_byte    = head.body_byte;
  assign out_ch.body_index   = head.body_index;
  assign out_ch.frame_ok     = head.frame_ok;
  assign out_ch.ack_needed   = head.ack_needed;
  assign out_ch.ack_target   = head.ack_target;
  assign out_ch.ack_check    = head.ack_check;
  assign out_ch.sequence_res = head.sequence_res;
  assign out_ch.has_identity = head.has_identity;
  assign out_ch.frame_length = head.frame_length;
  assign out_ch.run_last     = head.run_last;

endmodule
